### hdl/ibbt_pkg.sv
// shared types, constants and helpers for the instance bounding box table
`default_nettype none
package ibbt_pkg;

  // table and frame geometry
  localparam int unsigned ID_COUNT = 256;
  localparam int unsigned MAX_DIM  = 4096;

  // fixed field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned LABEL_W = 8;
  localparam int unsigned BOX_W   = 12;
  localparam int unsigned FW_W    = 13;

  // derived widths
  localparam int unsigned IDX_W   = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int unsigned COORD_W = $clog2(MAX_DIM);
  localparam int unsigned DIM_W   = COORD_W + 1;
  localparam int unsigned CMP_W   = (FW_W > DIM_W) ? FW_W : DIM_W;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET = FW_W'(1920);

  typedef enum logic [CMD_W-1:0] {
    CMD_PIXEL = 2'd0,
    CMD_READ  = 2'd1,
    CMD_START = 2'd2
  } cmd_e;

  // current raster position
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pos_t;

  // one accepted item together with its position
  typedef struct packed {
    cmd_e               cmd;
    logic [ID_W-1:0]    id;
    logic [LABEL_W-1:0] label;
    pos_t               pos;
  } item_t;

  // one table entry as kept in memory
  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [COORD_W-1:0] x_min;
    logic [COORD_W-1:0] x_max;
    logic [COORD_W-1:0] y_min;
    logic [COORD_W-1:0] y_max;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // status of the merge stage seen by the top level
  typedef struct packed {
    logic valid;
    logic is_read;
  } stage_t;

  // one read result
  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [LABEL_W-1:0] label;
    logic [BOX_W-1:0]   x_min;
    logic [BOX_W-1:0]   x_max;
    logic [BOX_W-1:0]   y_min;
    logic [BOX_W-1:0]   y_max;
  } result_t;

  // clamp a written frame width to the range 1 .. MAX_DIM
  function automatic logic [DIM_W-1:0] eff_width(input logic [FW_W-1:0] w);
    logic [CMP_W-1:0] wx;
    logic [DIM_W-1:0] r;
    wx = CMP_W'(w);
    if (wx == '0) begin
      r = DIM_W'(1);
    end else if (wx > CMP_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(wx);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/ibbt_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module ibbt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [$clog2(DEPTH)-1:0]       waddr_i,
  input  wire logic [WIDTH-1:0]               wdata_i,
  input  wire logic                           re_i,
  input  wire logic [$clog2(DEPTH)-1:0]       raddr_i,
  output logic      [WIDTH-1:0]               rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

### hdl/ibbt_position.sv
// column and row counters with the frame width register
`default_nettype none
module ibbt_position (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [ibbt_pkg::FW_W-1:0] cfg_width_i,
  input  wire logic                   acc_i,
  input  wire ibbt_pkg::cmd_e         cmd_i,
  output ibbt_pkg::pos_t              pos_o
);
  import ibbt_pkg::*;

  logic [DIM_W-1:0]   width_q, width_d;
  logic [COORD_W-1:0] col_q, col_d;
  logic [COORD_W-1:0] row_q, row_d;
  logic [DIM_W-1:0]   col_next;

  // width register holds the clamped value
  always_comb begin
    width_d = width_q;
    if (cfg_we_i) begin
      width_d = eff_width(cfg_width_i);
    end
  end

  // advance on every pixel, clear on start of frame
  always_comb begin
    col_next = DIM_W'(col_q) + DIM_W'(1);
    col_d    = col_q;
    row_d    = row_q;
    if (acc_i) begin
      case (cmd_i)
        CMD_PIXEL: begin
          if (col_next >= width_q) begin
            col_d = '0;
            if (row_q != COORD_W'(MAX_DIM - 1)) begin
              row_d = row_q + COORD_W'(1);
            end
          end else begin
            col_d = col_next[COORD_W-1:0];
          end
        end
        CMD_START: begin
          col_d = '0;
          row_d = '0;
        end
        default: begin
          col_d = col_q;
          row_d = row_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= eff_width(FRAME_WIDTH_RESET);
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      width_q <= width_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  assign pos_o.x = col_q;
  assign pos_o.y = row_q;

endmodule
`default_nettype wire

### hdl/ibbt_table.sv
// seen flags, entry memory and the merge stage with write forwarding
`default_nettype none
module ibbt_table (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            acc_i,
  input  wire ibbt_pkg::item_t item_i,
  input  wire logic            drain_i,
  output ibbt_pkg::stage_t     stage_o,
  output ibbt_pkg::result_t    result_o
);
  import ibbt_pkg::*;

  logic [ID_COUNT-1:0] seen_q, seen_d;
  logic                in_range;
  logic [IDX_W-1:0]    in_idx;

  logic                s1_valid_q, s1_valid_d;
  item_t               s1_q;
  logic                s1_seen_q;
  logic [IDX_W-1:0]    s1_idx;
  logic                s1_write;

  logic                wb_valid_q;
  logic [IDX_W-1:0]    wb_addr_q;
  entry_t              wb_data_q;

  entry_t              rd_data;
  entry_t              base;
  entry_t              merged;

  // table index of the incoming item
  assign in_range = ({1'b0, item_i.id} < (ID_W + 1)'(ID_COUNT));
  assign in_idx   = IDX_W'(item_i.id);

  // seen flags: set by the first pixel, cleared at once on start of frame
  always_comb begin
    seen_d = seen_q;
    if (acc_i) begin
      case (item_i.cmd)
        CMD_PIXEL: begin
          if (in_range && item_i.id != '0) begin
            seen_d[in_idx] = 1'b1;
          end
        end
        CMD_START: seen_d = '0;
        default:   seen_d = seen_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

  // merge stage register
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (acc_i) begin
      s1_valid_d = 1'b1;
    end else if (drain_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_q      <= item_i;
      s1_seen_q <= in_range && seen_q[in_idx];
    end
  end

  assign s1_idx = IDX_W'(s1_q.id);

  // entry memory, read as the item is taken
  ibbt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ID_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (s1_write),
    .waddr_i (s1_idx),
    .wdata_i (merged),
    .re_i    (acc_i),
    .raddr_i (in_idx),
    .rdata_o (rd_data)
  );

  // forward the last write over a stale memory read
  always_comb begin
    base = rd_data;
    if (wb_valid_q && wb_addr_q == s1_idx) begin
      base = wb_data_q;
    end
  end

  // widen the box, or start a one-point box on the first pixel
  always_comb begin
    if (!s1_seen_q) begin
      merged.label = s1_q.label;
      merged.x_min = s1_q.pos.x;
      merged.x_max = s1_q.pos.x;
      merged.y_min = s1_q.pos.y;
      merged.y_max = s1_q.pos.y;
    end else begin
      merged.label = base.label;
      merged.x_min = (s1_q.pos.x < base.x_min) ? s1_q.pos.x : base.x_min;
      merged.x_max = (s1_q.pos.x > base.x_max) ? s1_q.pos.x : base.x_max;
      merged.y_min = (s1_q.pos.y < base.y_min) ? s1_q.pos.y : base.y_min;
      merged.y_max = (s1_q.pos.y > base.y_max) ? s1_q.pos.y : base.y_max;
    end
  end

  assign s1_write = s1_valid_q && (s1_q.cmd == CMD_PIXEL) && (s1_q.id != '0) &&
                    ({1'b0, s1_q.id} < (ID_W + 1)'(ID_COUNT));

  // copy of the last write for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_valid_q <= 1'b0;
    end else if (s1_write) begin
      wb_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_write) begin
      wb_addr_q <= s1_idx;
      wb_data_q <= merged;
    end
  end

  // status and read result
  assign stage_o.valid   = s1_valid_q;
  assign stage_o.is_read = (s1_q.cmd == CMD_READ);

  assign result_o.valid = s1_seen_q;
  assign result_o.id    = s1_q.id;
  assign result_o.label = s1_seen_q ? base.label : '0;
  assign result_o.x_min = s1_seen_q ? BOX_W'(base.x_min) : '0;
  assign result_o.x_max = s1_seen_q ? BOX_W'(base.x_max) : '0;
  assign result_o.y_min = s1_seen_q ? BOX_W'(base.y_min) : '0;
  assign result_o.y_max = s1_seen_q ? BOX_W'(base.y_max) : '0;

endmodule
`default_nettype wire

### hdl/instance_bounding_box_table_unit.sv
// top level of the instance bounding box table
// Takes one transaction per clock: a pixel, a read of one table entry, or a
// start of frame. The column and row of each pixel come from internal counters
// that wrap at the configured frame width (0 acts as 1, widths above 4096 act
// as 4096) and the row saturates at 4095. Each item needs one read-modify-write
// of the entry memory: the memory is read as the item is taken, the box is
// merged and written back in the next cycle, and the last write is forwarded
// so an item may follow on the same id in the next cycle. A read result moves
// from the merge stage into the output register when that register is free;
// the input only stalls while a read result waits for a full output register.
// Valid marks sit in flip-flops, so start of frame clears them all at once and
// no clearing pass runs after reset. Write frame_width only while idle.
`default_nettype none
module instance_bounding_box_table_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write channel
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [ibbt_pkg::FW_W-1:0]    frame_width_i,
  // input channel
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [ibbt_pkg::CMD_W-1:0]   cmd_i,
  input  wire logic [ibbt_pkg::ID_W-1:0]    instance_id_i,
  input  wire logic [ibbt_pkg::LABEL_W-1:0] class_label_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              entry_valid_o,
  output logic      [ibbt_pkg::ID_W-1:0]    entry_id_o,
  output logic      [ibbt_pkg::LABEL_W-1:0] entry_label_o,
  output logic      [ibbt_pkg::BOX_W-1:0]   box_x_min_o,
  output logic      [ibbt_pkg::BOX_W-1:0]   box_x_max_o,
  output logic      [ibbt_pkg::BOX_W-1:0]   box_y_min_o,
  output logic      [ibbt_pkg::BOX_W-1:0]   box_y_max_o
);
  import ibbt_pkg::*;

  logic    in_acc;
  logic    cfg_we;
  logic    out_free;
  logic    hold;
  logic    load_out;
  pos_t    pos;
  item_t   item;
  stage_t  stage;
  result_t result;

  logic    out_valid_q, out_valid_d;
  result_t out_q;

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign out_free    = !out_valid_q || out_ready_i;
  assign hold        = stage.valid && stage.is_read && !out_free;
  assign in_ready_o  = !hold;
  assign in_acc      = in_valid_i && in_ready_o;
  assign load_out    = stage.valid && stage.is_read && out_free;

  ibbt_position u_position (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_width_i (frame_width_i),
    .acc_i       (in_acc),
    .cmd_i       (cmd_e'(cmd_i)),
    .pos_o       (pos)
  );

  // item with its raster position
  assign item.cmd   = cmd_e'(cmd_i);
  assign item.id    = instance_id_i;
  assign item.label = class_label_i;
  assign item.pos   = pos;

  ibbt_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (in_acc),
    .item_i   (item),
    .drain_i  (!hold),
    .stage_o  (stage),
    .result_o (result)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_valid_o = out_q.valid;
  assign entry_id_o    = out_q.id;
  assign entry_label_o = out_q.label;
  assign box_x_min_o   = out_q.x_min;
  assign box_x_max_o   = out_q.x_max;
  assign box_y_min_o   = out_q.y_min;
  assign box_y_max_o   = out_q.y_max;

endmodule
`default_nettype wire
